### hdl/text_console_cursor_scroll_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text console cursor/scroll block
// Short wrappers for concurrent checks, clocked on the rising edge, reset off.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_ASSERT_SVH

// Same-cycle implication
`define TCCS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TCCS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must never hold
`define TCCS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### hdl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types, widths and character codes for the text console engine.
// ----------------------------------------------------------------------------
package tccs_pkg;

  // Screen geometry defaults
  localparam int COLUMNS_DEFAULT     = 80;
  localparam int ROWS_DEFAULT        = 25;
  localparam int TAB_ADVANCE_DEFAULT = 4;

  // Port field widths
  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int POS_W     = 11;
  localparam int ROW_OUT_W = 5;
  localparam int COL_OUT_W = 7;
  localparam int CELL_W    = CHAR_W + ATTR_W;

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

  // Command codes on the input port
  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_CHAR  = 2'd0,
    CMD_BACKSPACE = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  // Classified operation handed to the execution side
  typedef enum logic [2:0] {
    OP_CHAR,
    OP_TAB,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CLEAR,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic [IDX_W-1:0]  cell_index;
  } op_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hdl/tccs_front.sv
// ----------------------------------------------------------------------------
// tccs_front
// Accepts command transactions and classifies them into queue operations.
// ----------------------------------------------------------------------------
module tccs_front (
  input  logic                          start,
  input  logic [tccs_pkg::CMD_W-1:0]    command,
  input  logic [tccs_pkg::CHAR_W-1:0]   char_code,
  input  logic [tccs_pkg::ATTR_W-1:0]   attribute,
  input  logic [tccs_pkg::IDX_W-1:0]    cell_index,
  input  tccs_pkg::q_stat_t             q_stat,
  output logic                          busy,
  output logic                          push,
  output tccs_pkg::op_t                 op
);
  import tccs_pkg::*;

  // Take a transaction whenever the queue has room
  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

  // Classify command and character
  always_comb begin
    op.char_code  = char_code;
    op.attribute  = attribute;
    op.cell_index = cell_index;
    unique case (cmd_t'(command))
      CMD_PUT_CHAR: begin
        if (char_code == CHAR_NEWLINE) begin
          op.kind = OP_NEWLINE;
        end else if (char_code == CHAR_TAB) begin
          op.kind = OP_TAB;
        end else begin
          op.kind = OP_CHAR;
        end
      end
      CMD_BACKSPACE: op.kind = OP_BACKSPACE;
      CMD_CLEAR:     op.kind = OP_CLEAR;
      CMD_READ:      op.kind = OP_READ;
      default:       op.kind = OP_READ;
    endcase
  end

endmodule

### hdl/tccs_queue.sv
// ----------------------------------------------------------------------------
// tccs_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module tccs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tccs_pkg::op_t     push_op,
  input  logic              pop,
  output tccs_pkg::op_t     head_op,
  output tccs_pkg::q_stat_t q_stat
);
  import tccs_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  op_t            entries [QUEUE_DEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] count;

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    if (p == QAW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return QAW'(p + 1'b1);
  endfunction

  assign head_op      = entries[rptr];
  assign q_stat.full  = (count == QCW'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ptr_inc(wptr);
      end
      if (pop) begin
        rptr <= ptr_inc(rptr);
      end
      if (push && !pop) begin
        count <= QCW'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCW'(count - 1'b1);
      end
    end
  end

endmodule

### hdl/tccs_back.sv
// ----------------------------------------------------------------------------
// tccs_back
// Executes operations: cursor update, screen memory writes and reads, scroll and clear.
// ----------------------------------------------------------------------------
module tccs_back #(
  parameter int COLUMNS     = tccs_pkg::COLUMNS_DEFAULT,
  parameter int ROWS        = tccs_pkg::ROWS_DEFAULT,
  parameter int TAB_ADVANCE = tccs_pkg::TAB_ADVANCE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tccs_pkg::op_t                    op,
  input  tccs_pkg::q_stat_t                q_stat,
  output logic                             pop,
  output logic                             done,
  output logic [tccs_pkg::POS_W-1:0]       cursor_pos,
  output logic [tccs_pkg::ROW_OUT_W-1:0]   cursor_row,
  output logic [tccs_pkg::COL_OUT_W-1:0]   cursor_col,
  output logic                             scrolled,
  output logic [tccs_pkg::CELL_W-1:0]      read_data
);
  import tccs_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + TAB_ADVANCE + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } state_t;

  state_t              state;
  logic [RW-1:0]       row;
  logic [CW-1:0]       col;
  logic [SW-1:0]       sweep;
  logic [AW-1:0]       dst;
  logic                rd_pend;
  logic                rd_ok;
  logic                scroll_flag;
  logic [CELL_W-1:0]   blank;

  logic [CELL_W-1:0]   mem [0:CELLS-1];
  logic [CELL_W-1:0]   rd_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [CELL_W-1:0]   wdata;

  logic [SW-1:0]       cur_addr;
  logic [CW-1:0]       col_adv;
  logic                wrap;
  logic                last_row;
  logic [RW-1:0]       row_inc;

  // Linear cell address of a cursor position
  function automatic logic [SW-1:0] lin(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return SW'(SW'(r) * SW'(COLUMNS) + SW'(c));
  endfunction

  // Cursor arithmetic for the head operation
  assign pop      = (state == ST_IDLE) && !q_stat.empty;
  assign cur_addr = lin(row, col);
  assign col_adv  = CW'(col + ((op.kind == OP_TAB) ? CW'(TAB_ADVANCE + 1) : CW'(1)));
  assign wrap     = (col_adv >= CW'(COLUMNS));
  assign last_row = (row == RW'(ROWS - 1));
  assign row_inc  = RW'(row + 1'b1);

  // Memory port selection
  always_comb begin
    we      = 1'b0;
    waddr   = AW'(cur_addr);
    wdata   = {op.attribute, op.char_code};
    rd_en   = 1'b0;
    rd_addr = AW'(op.cell_index);
    unique case (state)
      ST_IDLE: begin
        if (pop && op.kind == OP_CHAR) begin
          we = 1'b1;
        end else if (pop && op.kind == OP_BACKSPACE && col != '0) begin
          we    = 1'b1;
          waddr = AW'(cur_addr - 1'b1);
          wdata = {op.attribute, CHAR_SPACE};
        end
        rd_en = pop && op.kind == OP_READ;
      end
      ST_COPY: begin
        we      = rd_pend;
        waddr   = dst;
        wdata   = rd_data;
        rd_en   = (sweep != SW'(CELLS));
        rd_addr = AW'(sweep);
      end
      ST_FILL: begin
        we    = 1'b1;
        waddr = AW'(sweep);
        wdata = blank;
      end
      ST_READ: begin
      end
      default: begin
      end
    endcase
  end

  // Screen memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Sequencer, cursor and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row     <= '0;
      col     <= '0;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            unique case (op.kind)
              OP_CHAR, OP_TAB, OP_NEWLINE: begin
                if (op.kind != OP_NEWLINE && !wrap) begin
                  col        <= col_adv;
                  done       <= 1'b1;
                  cursor_pos <= POS_W'(lin(row, col_adv));
                  cursor_row <= ROW_OUT_W'(row);
                  cursor_col <= COL_OUT_W'(col_adv);
                  scrolled   <= 1'b0;
                  read_data  <= '0;
                end else if (!last_row) begin
                  col        <= '0;
                  row        <= row_inc;
                  done       <= 1'b1;
                  cursor_pos <= POS_W'(lin(row_inc, '0));
                  cursor_row <= ROW_OUT_W'(row_inc);
                  cursor_col <= '0;
                  scrolled   <= 1'b0;
                  read_data  <= '0;
                end else begin
                  // bottom row: move everything up one row
                  col         <= '0;
                  sweep       <= SW'(COLUMNS);
                  rd_pend     <= 1'b0;
                  blank       <= {op.attribute, CHAR_SPACE};
                  scroll_flag <= 1'b1;
                  state       <= ST_COPY;
                end
              end
              OP_BACKSPACE: begin
                done       <= 1'b1;
                cursor_row <= ROW_OUT_W'(row);
                scrolled   <= 1'b0;
                read_data  <= '0;
                if (col != '0) begin
                  col        <= CW'(col - 1'b1);
                  cursor_pos <= POS_W'(cur_addr - 1'b1);
                  cursor_col <= COL_OUT_W'(col - 1'b1);
                end else begin
                  cursor_pos <= POS_W'(cur_addr);
                  cursor_col <= COL_OUT_W'(col);
                end
              end
              OP_CLEAR: begin
                row         <= '0;
                col         <= '0;
                sweep       <= '0;
                blank       <= {op.attribute, CHAR_SPACE};
                scroll_flag <= 1'b0;
                state       <= ST_FILL;
              end
              OP_READ: begin
                rd_ok <= (32'(op.cell_index) < CELLS);
                state <= ST_READ;
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          done       <= 1'b1;
          cursor_pos <= POS_W'(cur_addr);
          cursor_row <= ROW_OUT_W'(row);
          cursor_col <= COL_OUT_W'(col);
          scrolled   <= 1'b0;
          read_data  <= rd_ok ? rd_data : '0;
          state      <= ST_IDLE;
        end
        ST_COPY: begin
          // read cell at sweep, write it one row up next cycle
          if (sweep != SW'(CELLS)) begin
            dst     <= AW'(sweep - SW'(COLUMNS));
            rd_pend <= 1'b1;
            sweep   <= SW'(sweep + 1'b1);
          end else begin
            rd_pend <= 1'b0;
            sweep   <= SW'(CELLS - COLUMNS);
            state   <= ST_FILL;
          end
        end
        ST_FILL: begin
          sweep <= SW'(sweep + 1'b1);
          if (sweep == SW'(CELLS - 1)) begin
            done       <= 1'b1;
            cursor_pos <= POS_W'(cur_addr);
            cursor_row <= ROW_OUT_W'(row);
            cursor_col <= COL_OUT_W'(col);
            scrolled   <= scroll_flag;
            read_data  <= '0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/text_console_cursor_scroll_top.sv
// Put char, tab, newline and backspace results pass through the queue and the result registers;
// a read cell also passes through the registered read port of the screen memory. The back end
// takes one character command per cycle while idle; a read, clear or scroll holds it out of idle.
// Clear and scroll sweep the screen one cell per cycle through the single write port;
// busy rises when the queue fills.
// Reset (synchronous) empties the queue and puts the cursor at 0,0; screen is not cleared.
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top
// Text console engine: command front end, operation queue and execution back end.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_top_assert.svh"

module text_console_cursor_scroll_top #(
  parameter int COLUMNS     = tccs_pkg::COLUMNS_DEFAULT,
  parameter int ROWS        = tccs_pkg::ROWS_DEFAULT,
  parameter int TAB_ADVANCE = tccs_pkg::TAB_ADVANCE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [tccs_pkg::CMD_W-1:0]       command,
  input  logic [tccs_pkg::CHAR_W-1:0]      char_code,
  input  logic [tccs_pkg::ATTR_W-1:0]      attribute,
  input  logic [tccs_pkg::IDX_W-1:0]       cell_index,
  output logic                             done,
  output logic [tccs_pkg::POS_W-1:0]       cursor_pos,
  output logic [tccs_pkg::ROW_OUT_W-1:0]   cursor_row,
  output logic [tccs_pkg::COL_OUT_W-1:0]   cursor_col,
  output logic                             scrolled,
  output logic [tccs_pkg::CELL_W-1:0]      read_data
);
  import tccs_pkg::*;

  op_t     push_op;
  op_t     head_op;
  q_stat_t q_stat;
  logic    push;
  logic    pop;

  // Front end: handshake and classification
  tccs_front u_front (
    .start      (start),
    .command    (command),
    .char_code  (char_code),
    .attribute  (attribute),
    .cell_index (cell_index),
    .q_stat     (q_stat),
    .busy       (busy),
    .push       (push),
    .op         (push_op)
  );

  // Operation queue
  tccs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .q_stat  (q_stat)
  );

  // Back end: cursor, screen memory, scroll and clear sweeps
  tccs_back #(
    .COLUMNS     (COLUMNS),
    .ROWS        (ROWS),
    .TAB_ADVANCE (TAB_ADVANCE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .op         (head_op),
    .q_stat     (q_stat),
    .pop        (pop),
    .done       (done),
    .cursor_pos (cursor_pos),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .scrolled   (scrolled),
    .read_data  (read_data)
  );

  // Checks
  `TCCS_ASSERT_IMPLY(a_scroll_cursor, clk, rst, done && scrolled, cursor_col == '0 && cursor_row == ROW_OUT_W'(ROWS - 1) && cursor_pos == POS_W'((ROWS - 1) * COLUMNS), "scroll result must leave cursor at start of last row")
  `TCCS_ASSERT_NEXT(a_accept_queued, clk, rst, start && !busy, !q_stat.empty, "accepted transaction missing from queue")
  `TCCS_ASSERT_NEVER(a_queue_stat, clk, rst, q_stat.full && q_stat.empty, "queue reports full and empty at once")
  `TCCS_ASSERT_NEVER(a_pop_empty, clk, rst, pop && q_stat.empty, "back end popped an empty queue")

endmodule

### tb/text_console_cursor_scroll_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_checker
// Watches the command and result ports of the text console engine. It keeps a
// mirror of the screen and cursor, predicts each result when a command
// transaction is taken, and compares results in order, field by field.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_checker #(
  parameter int COLUMNS     = tccs_pkg::COLUMNS_DEFAULT,
  parameter int ROWS        = tccs_pkg::ROWS_DEFAULT,
  parameter int TAB_ADVANCE = tccs_pkg::TAB_ADVANCE_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [tccs_pkg::CMD_W-1:0]     command,
  input  logic [tccs_pkg::CHAR_W-1:0]    char_code,
  input  logic [tccs_pkg::ATTR_W-1:0]    attribute,
  input  logic [tccs_pkg::IDX_W-1:0]     cell_index,
  input  logic                           done,
  input  logic [tccs_pkg::POS_W-1:0]     cursor_pos,
  input  logic [tccs_pkg::ROW_OUT_W-1:0] cursor_row,
  input  logic [tccs_pkg::COL_OUT_W-1:0] cursor_col,
  input  logic                           scrolled,
  input  logic [tccs_pkg::CELL_W-1:0]    read_data,
  output int                             fail_count,
  output int                             results_due
);
  import tccs_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;

  typedef struct packed {
    logic [POS_W-1:0]     pos;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 scrolled;
    logic [CELL_W-1:0]    data;
  } cursor_result_t;

  // Mirror of the screen and cursor
  logic [CELL_W-1:0] screen_mirror [0:CELL_COUNT-1];
  int                row_now = 0;
  int                col_now = 0;

  cursor_result_t    cursor_results_q [$];
  int                errors_seen = 0;

  task automatic log_error(input string what);
    errors_seen++;
    if (errors_seen <= 10) $display("ERROR at %0t ns: %s", $realtime, what);
  endtask

  task automatic check_field(input string field, input logic [31:0] want, got);
    if (want !== got)
      log_error($sformatf("%s: expected 0x%0h, got 0x%0h", field, want, got));
  endtask

  // Move to the next line; past the bottom row the screen moves up one row
  task automatic advance_row(input logic [CELL_W-1:0] blank, inout bit did_scroll);
    col_now = 0;
    row_now++;
    if (row_now >= ROWS) begin
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
        screen_mirror[i] = screen_mirror[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
        screen_mirror[i] = blank;
      row_now    = ROWS - 1;
      did_scroll = 1'b1;
    end
  endtask

  // Apply one command to the mirror and work out its result
  task automatic apply_console_cmd(input cmd_t op, input logic [CHAR_W-1:0] ch,
                                   input logic [ATTR_W-1:0] attr,
                                   input logic [IDX_W-1:0] idx,
                                   output cursor_result_t res);
    logic [CELL_W-1:0] blank;
    logic [CELL_W-1:0] data;
    bit                did_scroll;
    blank      = {attr, CHAR_SPACE};
    data       = '0;
    did_scroll = 1'b0;
    case (op)
      CMD_PUT_CHAR: begin
        if (ch == CHAR_NEWLINE) begin
          advance_row(blank, did_scroll);
        end else begin
          if (ch == CHAR_TAB) col_now += TAB_ADVANCE;
          else screen_mirror[row_now * COLUMNS + col_now] = {attr, ch};
          col_now++;
          // overshoot past the last column is dropped
          if (col_now >= COLUMNS) advance_row(blank, did_scroll);
        end
      end
      CMD_BACKSPACE: begin
        if (col_now > 0) begin
          col_now--;
          screen_mirror[row_now * COLUMNS + col_now] = blank;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++) screen_mirror[i] = blank;
        row_now = 0;
        col_now = 0;
      end
      default: begin
        // out-of-range index reads as zero
        if (idx < CELL_COUNT) data = screen_mirror[idx];
      end
    endcase
    res.pos      = POS_W'(row_now * COLUMNS + col_now);
    res.row      = ROW_OUT_W'(row_now);
    res.col      = COL_OUT_W'(col_now);
    res.scrolled = did_scroll;
    res.data     = data;
  endtask

  // Compare results, then predict for a newly taken transaction
  always @(posedge clk) begin : track_console
    cursor_result_t want;
    cursor_result_t taken;
    if (rst) begin
      row_now = 0;
      col_now = 0;
      cursor_results_q.delete();
    end else begin
      if (done) begin
        if (cursor_results_q.size() == 0) begin
          log_error($sformatf("result with no transaction pending: pos %0d data 0x%0h",
                              cursor_pos, read_data));
        end else begin
          want = cursor_results_q.pop_front();
          check_field("cursor_pos", 32'(want.pos), 32'(cursor_pos));
          check_field("cursor_row", 32'(want.row), 32'(cursor_row));
          check_field("cursor_col", 32'(want.col), 32'(cursor_col));
          check_field("scrolled", 32'(want.scrolled), 32'(scrolled));
          check_field("read_data", 32'(want.data), 32'(read_data));
        end
      end
      if (start && !busy) begin
        apply_console_cmd(cmd_t'(command), char_code, attribute, cell_index, taken);
        cursor_results_q.push_back(taken);
      end
    end
    results_due <= cursor_results_q.size();
    fail_count  <= errors_seen;
  end

endmodule

### tb/text_console_cursor_scroll_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top_tb
// Drives command transactions into the text console engine: a short directed
// sequence, then random runs of text, newlines, tabs, backspaces, reads and
// clears, sent in bursts with random gaps. A checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top_tb;
  import tccs_pkg::*;

  localparam int COLUMNS     = COLUMNS_DEFAULT;
  localparam int ROWS        = ROWS_DEFAULT;
  localparam int TAB_ADVANCE = TAB_ADVANCE_DEFAULT;
  localparam int CELL_COUNT  = COLUMNS * ROWS;
  localparam int IDX_MAX     = (1 << IDX_W) - 1;
  localparam int ITEM_TARGET = 750;
  // a clear or scroll walks the whole screen; allow several back to back
  localparam int STALL_LIMIT = 10 * CELL_COUNT + 1000;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 start      = 1'b0;
  logic [CMD_W-1:0]     command    = CMD_PUT_CHAR;
  logic [CHAR_W-1:0]    char_code  = '0;
  logic [ATTR_W-1:0]    attribute  = '0;
  logic [IDX_W-1:0]     cell_index = '0;
  logic                 busy;
  logic                 done;
  logic [POS_W-1:0]     cursor_pos;
  logic [ROW_OUT_W-1:0] cursor_row;
  logic [COL_OUT_W-1:0] cursor_col;
  logic                 scrolled;
  logic [CELL_W-1:0]    read_data;

  int fail_count;
  int results_due;
  int items_sent   = 0;
  int burst_left   = 0;
  int stall_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_console_cursor_scroll_top #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_ADVANCE(TAB_ADVANCE)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .char_code(char_code), .attribute(attribute),
    .cell_index(cell_index), .done(done), .cursor_pos(cursor_pos),
    .cursor_row(cursor_row), .cursor_col(cursor_col), .scrolled(scrolled),
    .read_data(read_data)
  );

  text_console_cursor_scroll_checker #(
    .COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_ADVANCE(TAB_ADVANCE)
  ) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .char_code(char_code), .attribute(attribute),
    .cell_index(cell_index), .done(done), .cursor_pos(cursor_pos),
    .cursor_row(cursor_row), .cursor_col(cursor_col), .scrolled(scrolled),
    .read_data(read_data), .fail_count(fail_count), .results_due(results_due)
  );

  // Watchdog: cycles with no transaction taken on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Bursts of back-to-back commands with random gaps between them
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Present one command and hold it until the block takes it
  task automatic send_cmd(input cmd_t op, input logic [CHAR_W-1:0] ch,
                          input logic [ATTR_W-1:0] attr, input logic [IDX_W-1:0] idx);
    start      <= 1'b1;
    command    <= op;
    char_code  <= ch;
    attribute  <= attr;
    cell_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    pace_sender();
  endtask

  // Hold off until every pending result has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] any_char();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [ATTR_W-1:0] any_attr();
    return ATTR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(0, IDX_MAX));
  endfunction

  function automatic logic [IDX_W-1:0] read_index();
    if ($urandom_range(0, 7) == 0) return IDX_W'($urandom_range(CELL_COUNT, IDX_MAX));
    return IDX_W'($urandom_range(0, CELL_COUNT - 1));
  endfunction

  initial begin : stimulus
    int          pick;
    int          run_len;
    int          k;
    logic [7:0]  ch;
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the screen is cleared first so no unwritten cell is read
    send_cmd(CMD_CLEAR, 8'hFF, 8'h00, 11'h7FF);
    send_cmd(CMD_BACKSPACE, 8'h00, 8'hFF, 11'd0);      // column 0: ignored
    send_cmd(CMD_READ, 8'h41, 8'h00, 11'd0);
    send_cmd(CMD_PUT_CHAR, 8'hFF, 8'hFF, 11'd0);
    send_cmd(CMD_PUT_CHAR, 8'h00, 8'h00, 11'h7FF);
    send_cmd(CMD_PUT_CHAR, 8'h41, 8'h5A, 11'd5);
    send_cmd(CMD_BACKSPACE, 8'h41, 8'hA5, 11'd0);
    send_cmd(CMD_READ, 8'h00, 8'h00, 11'd2);           // cell blanked above
    send_cmd(CMD_PUT_CHAR, CHAR_TAB, 8'h11, 11'd0);
    send_cmd(CMD_PUT_CHAR, CHAR_NEWLINE, 8'h3C, 11'd0);
    send_cmd(CMD_READ, 8'h00, 8'h00, IDX_W'(CELL_COUNT - 1));
    send_cmd(CMD_READ, 8'h00, 8'h00, IDX_W'(CELL_COUNT));  // out of range
    send_cmd(CMD_READ, 8'hFF, 8'hFF, 11'h7FF);
    send_cmd(CMD_CLEAR, 8'h00, 8'hFF, 11'd0);
    send_cmd(CMD_PUT_CHAR, 8'h7A, 8'h0F, 11'h7FF);
    drain_results();

    // Random runs; wrap, tab overshoot and scrolling come from these
    while (items_sent < ITEM_TARGET) begin
      pick    = $urandom_range(0, 99);
      run_len = $urandom_range(1, 40);
      for (k = 0; k < run_len && items_sent < ITEM_TARGET; k++) begin
        if (pick < 40) begin
          // text with occasional control bytes and arbitrary bytes
          case ($urandom_range(0, 19))
            0:       ch = CHAR_NEWLINE;
            1:       ch = CHAR_TAB;
            2:       ch = any_char();
            default: ch = CHAR_W'($urandom_range(32, 126));
          endcase
          send_cmd(CMD_PUT_CHAR, ch, any_attr(), any_index());
        end else if (pick < 55) begin
          send_cmd(CMD_PUT_CHAR, CHAR_NEWLINE, any_attr(), any_index());
        end else if (pick < 63) begin
          send_cmd(CMD_PUT_CHAR, CHAR_TAB, any_attr(), any_index());
        end else if (pick < 71) begin
          send_cmd(CMD_BACKSPACE, any_char(), any_attr(), any_index());
        end else if (pick < 85) begin
          send_cmd(CMD_READ, any_char(), any_attr(), read_index());
        end else if (pick < 95) begin
          // noise: any command, any fields
          send_cmd(cmd_t'(CMD_W'($urandom_range(0, 3))), any_char(), any_attr(),
                   any_index());
        end else begin
          send_cmd(CMD_CLEAR, any_char(), any_attr(), any_index());
          k = run_len;
        end
      end
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    // Let everything drain, then a few quiet cycles
    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### text_console_cursor_scroll_top.f
+incdir+hdl
hdl/tccs_pkg.sv
hdl/tccs_front.sv
hdl/tccs_queue.sv
hdl/tccs_back.sv
hdl/text_console_cursor_scroll_top.sv
tb/text_console_cursor_scroll_checker.sv
tb/text_console_cursor_scroll_top_tb.sv
